>>> hdl/button_repeat_focus_stepper_defines.svh
// Assertion macros shared by the focus stepper RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BUTTON_REPEAT_FOCUS_STEPPER_DEFINES_SVH
`define BUTTON_REPEAT_FOCUS_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define BRFS_ASSERT_NOW(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define BRFS_ASSERT_NEXT(lbl, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error("assertion failed");

`endif

>>> hdl/brfs_pkg.sv
// Package for the button focus stepper: direction codes, register map, limits.
// No dependencies.
package brfs_pkg;

	// Upper bound on selectable items; the 8-bit index caps it further at 256
	localparam int unsigned MAX_ITEMS = 256;
	localparam int unsigned ITEM_CAP_INT = (MAX_ITEMS < 256) ? MAX_ITEMS : 256;
	localparam logic [8:0] ITEM_CAP = 9'(ITEM_CAP_INT);

	// Reset values of the timing registers
	localparam logic [15:0] DEBOUNCE_RST = 16'd130;
	localparam logic [15:0] INIT_DELAY_RST = 16'd700;
	localparam logic [15:0] REPEAT_INT_RST = 16'd95;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_WORD_COUNT = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_INIT_DELAY = 2'd2;
	localparam logic [1:0] REG_REPEAT_INT = 2'd3;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_LEFT = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

endpackage

>>> hdl/button_repeat_focus_stepper.sv
// Button auto-repeat with debounce driving a clamped focus index.
// Depends on brfs_pkg and button_repeat_focus_stepper_defines.svh.
`include "button_repeat_focus_stepper_defines.svh"

// One sample per transaction in, one result per transaction out. A sample is
// registered at the input, updated against the debounce and repeat state in
// combinational logic, and the result is registered at the output, so the
// block accepts one sample per clock while the output side is ready. The
// rate is set by the state update loop (edge time, repeat deadline, focus
// index). Registers sit at byte addresses 0 (word_count), 4 (debounce_ms),
// 8 (initial_delay_ms) and 12 (repeat_interval_ms); write them only while
// the block is idle.
module button_repeat_focus_stepper (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now_ms[31:0], left_edge[32], right_edge[33], left_held[34], right_held[35], zero[39:36]
	input  logic [39:0] s_axis_tdata,
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// focus_index[7:0], handled[8], moved[9], zero[15:10]
	output logic [15:0] m_axis_tdata
);

	// Configuration registers
	logic [8:0]  word_count_q;
	logic [15:0] debounce_q;
	logic [15:0] init_delay_q;
	logic [15:0] repeat_int_q;

	// Input stage
	logic        valid_s1;
	logic [31:0] now_s1;
	logic        ledge_s1, redge_s1, lheld_s1, rheld_s1;

	// Output stage
	logic        valid_s2;
	logic [7:0]  focus_s2;
	logic        handled_s2, moved_s2;

	// Stepper state
	brfs_pkg::dir_t last_dir_q, rep_dir_q;
	logic [31:0]    last_time_q, next_rep_q;
	logic [7:0]     focus_q;

	// Next-state values
	brfs_pkg::dir_t last_dir_d, rep_dir_d, edge_dir;
	logic [31:0]    last_time_d, next_rep_d, since_edge;
	logic [7:0]     focus_d;
	logic           handled_d, moved_d;
	logic           do_step, step_fwd, bounce;
	logic [8:0]     lim;

	logic advance, process, cfg_wr;

	// Handshake: output register frees when empty or taken
	assign advance       = !valid_s2 || m_axis_tready;
	assign process       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, moved_s2, handled_s2, focus_s2};

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			debounce_q   <= brfs_pkg::DEBOUNCE_RST;
			init_delay_q <= brfs_pkg::INIT_DELAY_RST;
			repeat_int_q <= brfs_pkg::REPEAT_INT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				brfs_pkg::REG_WORD_COUNT: word_count_q <= pwdata[8:0];
				brfs_pkg::REG_DEBOUNCE:   debounce_q   <= pwdata[15:0];
				brfs_pkg::REG_INIT_DELAY: init_delay_q <= pwdata[15:0];
				brfs_pkg::REG_REPEAT_INT: repeat_int_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			brfs_pkg::REG_WORD_COUNT: prdata = {23'd0, word_count_q};
			brfs_pkg::REG_DEBOUNCE:   prdata = {16'd0, debounce_q};
			brfs_pkg::REG_INIT_DELAY: prdata = {16'd0, init_delay_q};
			brfs_pkg::REG_REPEAT_INT: prdata = {16'd0, repeat_int_q};
			default:                  prdata = '0;
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			now_s1   <= s_axis_tdata[31:0];
			ledge_s1 <= s_axis_tdata[32];
			redge_s1 <= s_axis_tdata[33];
			lheld_s1 <= s_axis_tdata[34];
			rheld_s1 <= s_axis_tdata[35];
		end
	end

	// Edge debounce, repeat deadline and focus step
	always_comb begin
		lim        = (word_count_q > brfs_pkg::ITEM_CAP) ? brfs_pkg::ITEM_CAP : word_count_q;
		edge_dir   = ledge_s1 ? brfs_pkg::DIR_LEFT : brfs_pkg::DIR_RIGHT;
		since_edge = now_s1 - last_time_q;
		bounce     = (last_dir_q == edge_dir) && (since_edge < {16'd0, debounce_q});

		last_dir_d  = last_dir_q;
		last_time_d = last_time_q;
		rep_dir_d   = rep_dir_q;
		next_rep_d  = next_rep_q;
		handled_d   = 1'b0;
		moved_d     = 1'b0;
		do_step     = 1'b0;
		step_fwd    = 1'b0;

		if (ledge_s1 || redge_s1) begin
			handled_d = 1'b1;
			if (!bounce) begin
				last_dir_d  = edge_dir;
				last_time_d = now_s1;
				rep_dir_d   = edge_dir;
				next_rep_d  = now_s1 + {16'd0, init_delay_q};
				moved_d     = 1'b1;
				do_step     = 1'b1;
				step_fwd    = (edge_dir == brfs_pkg::DIR_RIGHT);
			end
		end else if (!lheld_s1 && !rheld_s1) begin
			rep_dir_d = brfs_pkg::DIR_NONE;
		end else if (rep_dir_q != brfs_pkg::DIR_NONE && now_s1 >= next_rep_q) begin
			// deadline reached: step only if the armed button is still down
			if ((rep_dir_q == brfs_pkg::DIR_LEFT && lheld_s1) ||
			    (rep_dir_q == brfs_pkg::DIR_RIGHT && rheld_s1)) begin
				moved_d    = 1'b1;
				handled_d  = 1'b1;
				do_step    = 1'b1;
				step_fwd   = (rep_dir_q == brfs_pkg::DIR_RIGHT);
				next_rep_d = now_s1 + {16'd0, repeat_int_q};
			end else begin
				rep_dir_d = brfs_pkg::DIR_NONE;
			end
		end

		// clamped move within 0 .. lim-1; no move when lim is zero
		focus_d = focus_q;
		if (do_step && lim != 9'd0) begin
			if (!step_fwd) begin
				if (focus_q != 8'd0) begin
					focus_d = focus_q - 8'd1;
				end
			end else if (({1'b0, focus_q} + 9'd1) < lim) begin
				focus_d = focus_q + 8'd1;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q  <= brfs_pkg::DIR_NONE;
			last_time_q <= '0;
			rep_dir_q   <= brfs_pkg::DIR_NONE;
			next_rep_q  <= '0;
			focus_q     <= '0;
		end else if (process) begin
			last_dir_q  <= last_dir_d;
			last_time_q <= last_time_d;
			rep_dir_q   <= rep_dir_d;
			next_rep_q  <= next_rep_d;
			focus_q     <= focus_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			focus_s2   <= focus_d;
			handled_s2 <= handled_d;
			moved_s2   <= moved_d;
		end
	end

	// Checks
	`BRFS_ASSERT_NOW(a_moved_handled, valid_s2, !moved_s2 || handled_s2)
	`BRFS_ASSERT_NEXT(a_hold_focus, process && !moved_d, $stable(focus_q))
	`BRFS_ASSERT_NOW(a_stall_full, !s_axis_tready, valid_s1 && valid_s2)
	`BRFS_ASSERT_NEXT(a_edge_recorded, process && moved_d && (ledge_s1 || redge_s1),
		last_dir_q != brfs_pkg::DIR_NONE && rep_dir_q == last_dir_q)

endmodule
